// ===== sv/assert_macros.svh =====
// Assertion macros shared by the x86 decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define X86D_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("x86d assertion failed");
`define X86D_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("x86d forbidden condition seen");
`else
`define X86D_ASSERT(lbl, clk, rst, prop)
`define X86D_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== sv/x86d_pkg.sv =====
// Types, constants and opcode classification for the x86 decoder.
package x86d_pkg;

   typedef enum logic [5:0] {
      PH_OPCODE = 6'b000001,
      PH_MODRM  = 6'b000010,
      PH_DISP   = 6'b000100,
      PH_IMM    = 6'b001000,
      PH_SHORT  = 6'b010000,
      PH_AAM    = 6'b100000
   } phase_type;

   typedef enum logic [3:0] {
      FM_NONE,
      FM_UNSUP,
      FM_PREFIX,
      FM_MODRM,
      FM_GRPIMM,
      FM_TEST,
      FM_IMM8,
      FM_IMM16,
      FM_SHORT,
      FM_AAM
   } form_type;

   localparam logic [2:0] SEG_NONE   = 3'd0;
   localparam logic       STATUS_OK  = 1'b0;
   localparam logic       STATUS_UNSUP = 1'b1;
   localparam logic [2:0] LEN_MAX    = 3'd7;
   localparam logic [2:0] RM_DIRECT  = 3'b110;
   localparam logic [2:0] REG_TEST   = 3'd0;
   localparam logic [7:0] OP_GRP_IMM16 = 8'h81;
   localparam logic [7:0] OP_TEST_W  = 8'hF7;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  held_opcode;
      logic [7:0]  held_modrm;
      logic [15:0] disp_accum;
      logic [15:0] imm_accum;
      logic [1:0]  bytes_pending;
      logic [2:0]  held_prefix;
      logic [15:0] addr_counter;
      logic [15:0] instr_start;
      logic [2:0]  byte_count;
   } state_type;

   typedef struct packed {
      logic [7:0]         opcode;
      logic [2:0]         op_extension;
      logic [1:0]         mode_field;
      logic [2:0]         rm_field;
      logic               has_modrm;
      logic signed [15:0] displacement;
      logic [15:0]        immediate;
      logic [2:0]         segment_prefix;
      logic [15:0]        branch_target;
      logic [15:0]        instr_address;
      logic [2:0]         length;
      logic               status;
   } rec_type;

   function automatic form_type form_of(input logic [7:0] op);
      form_type f;
      f = FM_NONE;
      if (op == 8'h26 || op == 8'h2E || op == 8'h36 || op == 8'h3E) f = FM_PREFIX;
      else if (op < 8'h40) begin
         if (op[2:0] < 3'd4) f = FM_MODRM;
         else if (op[2:0] == 3'd4) f = FM_IMM8;
         else if (op[2:0] == 3'd5) f = FM_IMM16;
         else f = FM_NONE;
      end
      else if (op < 8'h70) f = FM_NONE;
      else if (op < 8'h80) f = FM_SHORT;
      else if (op < 8'h84) f = FM_GRPIMM;
      else if (op == 8'h8C || op == 8'h8E) f = FM_UNSUP;
      else if (op < 8'h90) f = FM_MODRM;
      else if (op == 8'h90 || op == 8'h9A) f = FM_UNSUP;
      else if (op < 8'hA0) f = FM_NONE;
      else if (op == 8'hA8) f = FM_IMM8;
      else if (op == 8'hA9) f = FM_IMM16;
      else if (op < 8'hB0) f = FM_UNSUP;
      else if (op < 8'hB8) f = FM_IMM8;
      else if (op < 8'hC0) f = FM_IMM16;
      else if (op == 8'hC2 || op == 8'hCA) f = FM_IMM16;
      else if (op == 8'hC4 || op == 8'hC5) f = FM_MODRM;
      else if (op == 8'hC6 || op == 8'hC7) f = FM_UNSUP;
      else if (op == 8'hCD) f = FM_IMM8;
      else if (op < 8'hD0) f = FM_NONE;
      else if (op < 8'hD4) f = FM_MODRM;
      else if (op == 8'hD4) f = FM_AAM;
      else if (op == 8'hD5 || op == 8'hD6) f = FM_NONE;
      else if (op < 8'hE0) f = FM_UNSUP;
      else if (op < 8'hE4 || op == 8'hEB) f = FM_SHORT;
      else if (op < 8'hE8) f = FM_IMM8;
      else if (op < 8'hEB) f = FM_UNSUP;
      else if (op == 8'hF6 || op == 8'hF7) f = FM_TEST;
      else if (op >= 8'hFE) f = FM_MODRM;
      else f = FM_NONE;
      return f;
   endfunction

   function automatic logic [1:0] disp_len(input logic [7:0] m);
      logic [1:0] n;
      n = 2'd0;
      case (m[7:6])
         2'd0: n = (m[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
         2'd1: n = 2'd1;
         2'd2: n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic logic [1:0] imm_len(input logic [7:0] op, input logic [7:0] m);
      form_type f;
      logic [1:0] n;
      f = form_of(op);
      n = 2'd0;
      case (f)
         FM_IMM8:   n = 2'd1;
         FM_IMM16:  n = 2'd2;
         FM_GRPIMM: n = (op == OP_GRP_IMM16) ? 2'd2 : 2'd1;
         FM_TEST: begin
            if (m[5:3] == REG_TEST) n = (op == OP_TEST_W) ? 2'd2 : 2'd1;
         end
         default:   n = 2'd0;
      endcase
      return n;
   endfunction

   function automatic state_type clear_state(input state_type s);
      state_type c;
      c = s;
      c.phase         = PH_OPCODE;
      c.held_opcode   = 8'h00;
      c.held_modrm    = 8'h00;
      c.disp_accum    = 16'h0000;
      c.imm_accum     = 16'h0000;
      c.bytes_pending = 2'd0;
      c.held_prefix   = SEG_NONE;
      c.byte_count    = 3'd0;
      return c;
   endfunction

endpackage

// ===== sv/x86d_step.sv =====
// Next-state and record logic for one code byte of the x86 decoder.
module x86d_step (
   input  x86d_pkg::state_type state_cur,
   input  logic [7:0]          code_byte,
   output x86d_pkg::state_type state_nxt,
   output logic                rec_emit,
   output x86d_pkg::rec_type   rec
);

   x86d_pkg::state_type c;
   x86d_pkg::form_type  f_byte;
   x86d_pkg::form_type  f_rec;
   logic [1:0]  dl_byte;
   logic [1:0]  dl_held;
   logic [1:0]  il_byte;
   logic [1:0]  il_held;
   logic [1:0]  total;
   logic [1:0]  pend_dec;
   logic        byte_hi;
   logic        status;
   logic        clear;
   logic        mr;
   logic [15:0] target;
   logic [15:0] placed;

   always_comb begin
      f_byte  = x86d_pkg::form_of(code_byte);
      dl_byte = x86d_pkg::disp_len(code_byte);
      dl_held = x86d_pkg::disp_len(state_cur.held_modrm);
      il_byte = x86d_pkg::imm_len(state_cur.held_opcode, code_byte);
      il_held = x86d_pkg::imm_len(state_cur.held_opcode, state_cur.held_modrm);
      pend_dec = (state_cur.bytes_pending != 2'd0) ? state_cur.bytes_pending - 2'd1 : 2'd0;
      total = (state_cur.phase == x86d_pkg::PH_DISP) ? dl_held : il_held;
      byte_hi = total[0] ^ state_cur.bytes_pending[0];
      placed = byte_hi ? {code_byte, 8'h00} : {8'h00, code_byte};

      c = state_cur;
      rec_emit = 1'b0;
      status = x86d_pkg::STATUS_OK;
      clear = 1'b0;
      c.addr_counter = state_cur.addr_counter + 16'd1;
      if (state_cur.phase == x86d_pkg::PH_OPCODE && state_cur.byte_count == 3'd0)
         c.instr_start = state_cur.addr_counter;
      if (state_cur.byte_count != x86d_pkg::LEN_MAX)
         c.byte_count = state_cur.byte_count + 3'd1;
      target = c.addr_counter + {{8{code_byte[7]}}, code_byte};

      unique case (state_cur.phase)
         x86d_pkg::PH_OPCODE: begin
            c.held_opcode = code_byte;
            case (f_byte)
               x86d_pkg::FM_PREFIX: c.held_prefix = {1'b0, code_byte[4:3]} + 3'd1;
               x86d_pkg::FM_NONE:   rec_emit = 1'b1;
               x86d_pkg::FM_UNSUP: begin
                  rec_emit = 1'b1;
                  status = x86d_pkg::STATUS_UNSUP;
               end
               x86d_pkg::FM_IMM8: begin
                  c.phase = x86d_pkg::PH_IMM;
                  c.bytes_pending = 2'd1;
               end
               x86d_pkg::FM_IMM16: begin
                  c.phase = x86d_pkg::PH_IMM;
                  c.bytes_pending = 2'd2;
               end
               x86d_pkg::FM_SHORT: c.phase = x86d_pkg::PH_SHORT;
               x86d_pkg::FM_AAM:   c.phase = x86d_pkg::PH_AAM;
               default:            c.phase = x86d_pkg::PH_MODRM;
            endcase
         end
         x86d_pkg::PH_MODRM: begin
            c.held_modrm = code_byte;
            if (dl_byte != 2'd0) begin
               c.phase = x86d_pkg::PH_DISP;
               c.bytes_pending = dl_byte;
            end else if (il_byte != 2'd0) begin
               c.phase = x86d_pkg::PH_IMM;
               c.bytes_pending = il_byte;
            end else begin
               rec_emit = 1'b1;
            end
         end
         x86d_pkg::PH_DISP: begin
            c.disp_accum = state_cur.disp_accum | placed;
            c.bytes_pending = pend_dec;
            if (pend_dec == 2'd0) begin
               if (dl_held == 2'd1 && c.disp_accum[7]) c.disp_accum[15:8] = 8'hFF;
               if (il_held != 2'd0) begin
                  c.phase = x86d_pkg::PH_IMM;
                  c.bytes_pending = il_held;
               end else begin
                  rec_emit = 1'b1;
               end
            end
         end
         x86d_pkg::PH_IMM: begin
            c.imm_accum = state_cur.imm_accum | placed;
            c.bytes_pending = pend_dec;
            if (pend_dec == 2'd0) rec_emit = 1'b1;
         end
         x86d_pkg::PH_SHORT: begin
            c.disp_accum = {{8{code_byte[7]}}, code_byte};
            rec_emit = 1'b1;
         end
         x86d_pkg::PH_AAM: clear = 1'b1;
         default:          clear = 1'b1;
      endcase

      f_rec = x86d_pkg::form_of(c.held_opcode);
      mr = (status == x86d_pkg::STATUS_OK) &&
           (f_rec == x86d_pkg::FM_MODRM || f_rec == x86d_pkg::FM_GRPIMM ||
            f_rec == x86d_pkg::FM_TEST);

      rec.opcode = c.held_opcode;
      rec.op_extension = 3'd0;
      if (mr) begin
         rec.op_extension = c.held_modrm[5:3];
      end else if (status == x86d_pkg::STATUS_OK) begin
         case (c.held_opcode) inside
            [8'h40:8'h5F], [8'h91:8'h97], [8'hB0:8'hBF]:
               rec.op_extension = c.held_opcode[2:0];
            default: rec.op_extension = 3'd0;
         endcase
      end
      rec.mode_field     = mr ? c.held_modrm[7:6] : 2'd0;
      rec.rm_field       = mr ? c.held_modrm[2:0] : 3'd0;
      rec.has_modrm      = mr;
      rec.displacement   = status ? 16'sd0 : $signed(c.disp_accum);
      rec.immediate      = status ? 16'd0 : c.imm_accum;
      rec.segment_prefix = c.held_prefix;
      rec.branch_target  = (status == x86d_pkg::STATUS_OK && f_rec == x86d_pkg::FM_SHORT) ?
                           target : 16'd0;
      rec.instr_address  = c.instr_start;
      rec.length         = c.byte_count;
      rec.status         = status;

      state_nxt = (rec_emit || clear) ? x86d_pkg::clear_state(c) : c;
   end

endmodule

// ===== sv/x86_16_instruction_decoder.sv =====
// Top level of the byte-serial x86 16-bit instruction decoder.
// Throughput: one code byte per cycle, sustained, while results are taken and csr_valid is low.
// A record is registered and appears on rsp_ in the cycle after the transfer of its last byte.
// req_stall rises while the result register is full and stalled, while csr_valid is high, or while live_ff is clear.
// Reset (synchronous) clears the decode state, sets both address counters to 0
// and clears live_ff, which holds req_stall high and csr_ready low.
`include "assert_macros.svh"

module x86_16_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_code_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_opcode,
   output logic [2:0]         rsp_op_extension,
   output logic [1:0]         rsp_mode_field,
   output logic [2:0]         rsp_rm_field,
   output logic               rsp_has_modrm,
   output logic signed [15:0] rsp_displacement,
   output logic [15:0]        rsp_immediate,
   output logic [2:0]         rsp_segment_prefix,
   output logic [15:0]        rsp_branch_target,
   output logic [15:0]        rsp_instr_address,
   output logic [2:0]         rsp_length,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_start_address
);

   x86d_pkg::state_type state_ff;
   x86d_pkg::state_type state_in;
   x86d_pkg::state_type step_nxt;
   x86d_pkg::rec_type   step_rec;
   x86d_pkg::rec_type   rsp_rec_ff;
   logic                step_emit;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                live_ff;
   logic                csr_wr;
   logic                byte_xfer;

   x86d_step u_step (
      .state_cur (state_ff),
      .code_byte (req_code_byte),
      .state_nxt (step_nxt),
      .rec_emit  (step_emit),
      .rec       (step_rec)
   );

   assign csr_ready = live_ff;
   assign req_stall = ~live_ff | (rsp_valid_ff & rsp_stall) | csr_valid;
   assign csr_wr    = csr_valid & csr_ready;
   assign byte_xfer = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      if (csr_wr) begin
         state_in = x86d_pkg::clear_state(state_ff);
         state_in.addr_counter = csr_start_address;
         state_in.instr_start  = csr_start_address;
      end else if (byte_xfer) begin
         state_in = step_nxt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (byte_xfer && step_emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= x86d_pkg::clear_state('0);
      end else begin
         live_ff      <= 1'b1;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_xfer && step_emit) rsp_rec_ff <= step_rec;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_opcode         = rsp_rec_ff.opcode;
   assign rsp_op_extension   = rsp_rec_ff.op_extension;
   assign rsp_mode_field     = rsp_rec_ff.mode_field;
   assign rsp_rm_field       = rsp_rec_ff.rm_field;
   assign rsp_has_modrm      = rsp_rec_ff.has_modrm;
   assign rsp_displacement   = rsp_rec_ff.displacement;
   assign rsp_immediate      = rsp_rec_ff.immediate;
   assign rsp_segment_prefix = rsp_rec_ff.segment_prefix;
   assign rsp_branch_target  = rsp_rec_ff.branch_target;
   assign rsp_instr_address  = rsp_rec_ff.instr_address;
   assign rsp_length         = rsp_rec_ff.length;
   assign rsp_status         = rsp_rec_ff.status;

   `X86D_ASSERT(a_csr_restarts, clock, reset, csr_wr |=> state_ff.phase == x86d_pkg::PH_OPCODE && state_ff.byte_count == 3'd0)
   `X86D_ASSERT(a_addr_advance, clock, reset, byte_xfer |=> state_ff.addr_counter == $past(state_ff.addr_counter) + 16'd1)
   `X86D_NEVER(n_zero_length, clock, reset, rsp_valid_ff && rsp_rec_ff.length == 3'd0)
   `X86D_NEVER(n_unsup_operands, clock, reset, rsp_valid_ff && rsp_rec_ff.status == x86d_pkg::STATUS_UNSUP && (rsp_rec_ff.has_modrm || rsp_rec_ff.immediate != 16'd0 || rsp_rec_ff.displacement != 16'sd0))
   `X86D_NEVER(n_idle_midinstr, clock, reset, state_ff.byte_count == 3'd0 && state_ff.phase != x86d_pkg::PH_OPCODE)

endmodule
